// ===== src/mlqss_pkg.sv =====
package mlqss_pkg;

    localparam int PRIO_LEVELS = 8;
    localparam int QUEUE_DEPTH = 16;

    localparam int LEVEL_W  = $clog2(PRIO_LEVELS);
    localparam int PTR_W    = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int CREDIT_W = $clog2(PRIO_LEVELS + 1);
    localparam int ADDR_W   = $clog2(PRIO_LEVELS * QUEUE_DEPTH);
    localparam int ID_W     = 8;

    typedef logic [LEVEL_W-1:0]  level_t;
    typedef logic [PTR_W-1:0]    ptr_t;
    typedef logic [COUNT_W-1:0]  count_t;
    typedef logic [COUNT_W:0]    ptr_sum_t;
    typedef logic [CREDIT_W-1:0] credit_t;
    typedef logic [ADDR_W-1:0]   addr_t;
    typedef logic [ID_W-1:0]     id_t;

    typedef enum logic [1:0] {
        ACT_ENQ  = 2'd0,
        ACT_DEQ  = 2'd1,
        ACT_SLOT = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_DROP   = 2'd1,
        STAT_RELOAD = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_RESP
    } state_t;

    // request from the sequencer to the queue store
    typedef struct packed {
        logic  we;
        logic  re;
        addr_t addr;
        id_t   wdata;
    } mem_req_t;

    // flat address of one FIFO slot: level-major layout
    function automatic addr_t slot_addr(level_t lvl, ptr_t pos);
        logic [31:0] flat;
        flat = 32'(lvl) * QUEUE_DEPTH + 32'(pos);
        return addr_t'(flat);
    endfunction

    function automatic credit_t credit_init(int lv);
        return credit_t'(PRIO_LEVELS - lv);
    endfunction

endpackage

// ===== src/mlqss_store.sv =====
module mlqss_store (
    input  logic                clk,
    input  mlqss_pkg::mem_req_t req,
    output mlqss_pkg::id_t      rd_data
);

    mlqss_pkg::id_t mem [mlqss_pkg::PRIO_LEVELS * mlqss_pkg::QUEUE_DEPTH];
    mlqss_pkg::id_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_data_reg <= mem[req.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/mlqss_seq.sv =====
module mlqss_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [1:0]           action,
    input  logic [2:0]           priority_req,
    input  logic [7:0]           process_id,
    input  mlqss_pkg::id_t       rd_data,
    output mlqss_pkg::mem_req_t  mem_req,
    output logic                 busy,
    output logic                 done,
    output logic [7:0]           granted_id,
    output logic                 granted,
    output logic [1:0]           status,
    output logic                 all_empty
);

    localparam int NL = mlqss_pkg::PRIO_LEVELS;

    mlqss_pkg::state_t  state_reg, state_next;
    mlqss_pkg::action_t act_reg, act_next;
    mlqss_pkg::status_t status_reg, status_next;
    mlqss_pkg::id_t     pid_reg, pid_next;
    mlqss_pkg::level_t  cur_reg, cur_next;
    logic               lvl_ok_reg, lvl_ok_next;
    logic               granted_reg, granted_next;
    logic [NL-1:0]      nonempty_reg, nonempty_next;

    mlqss_pkg::ptr_t    head_reg   [NL];
    mlqss_pkg::ptr_t    head_next  [NL];
    mlqss_pkg::count_t  count_reg  [NL];
    mlqss_pkg::count_t  count_next [NL];
    mlqss_pkg::credit_t credit_reg [NL];
    mlqss_pkg::credit_t credit_next[NL];

    mlqss_pkg::ptr_sum_t wr_sum;
    mlqss_pkg::ptr_t     wr_pos;
    mlqss_pkg::ptr_t     head_inc;
    logic                accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= mlqss_pkg::ST_IDLE;
            nonempty_reg <= '0;
            for (int lv = 0; lv < NL; lv++)
            begin
                head_reg[lv]   <= '0;
                count_reg[lv]  <= '0;
                credit_reg[lv] <= mlqss_pkg::credit_init(lv);
            end
        end
        else
        begin
            state_reg    <= state_next;
            nonempty_reg <= nonempty_next;
            for (int lv = 0; lv < NL; lv++)
            begin
                head_reg[lv]   <= head_next[lv];
                count_reg[lv]  <= count_next[lv];
                credit_reg[lv] <= credit_next[lv];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg     <= act_next;
        status_reg  <= status_next;
        pid_reg     <= pid_next;
        cur_reg     <= cur_next;
        lvl_ok_reg  <= lvl_ok_next;
        granted_reg <= granted_next;
    end

    // tail slot and advanced head of the current level, wrapped at the depth
    always_comb
    begin
        wr_sum = mlqss_pkg::ptr_sum_t'(head_reg[cur_reg])
               + mlqss_pkg::ptr_sum_t'(count_reg[cur_reg]);
        if (wr_sum >= mlqss_pkg::ptr_sum_t'(mlqss_pkg::QUEUE_DEPTH))
        begin
            wr_sum = wr_sum - mlqss_pkg::ptr_sum_t'(mlqss_pkg::QUEUE_DEPTH);
        end
        wr_pos = mlqss_pkg::ptr_t'(wr_sum);
        if (head_reg[cur_reg] == mlqss_pkg::ptr_t'(mlqss_pkg::QUEUE_DEPTH - 1))
        begin
            head_inc = '0;
        end
        else
        begin
            head_inc = head_reg[cur_reg] + mlqss_pkg::ptr_t'(1);
        end
    end

    assign accept = start && (state_reg == mlqss_pkg::ST_IDLE ||
                              state_reg == mlqss_pkg::ST_RESP);

    always_comb
    begin
        state_next    = state_reg;
        act_next      = act_reg;
        status_next   = status_reg;
        pid_next      = pid_reg;
        cur_next      = cur_reg;
        lvl_ok_next   = lvl_ok_reg;
        granted_next  = granted_reg;
        nonempty_next = nonempty_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        credit_next   = credit_reg;
        mem_req       = '0;

        case (state_reg)
            mlqss_pkg::ST_IDLE, mlqss_pkg::ST_RESP:
            begin
                if (accept)
                begin
                    act_next     = mlqss_pkg::action_t'(action);
                    pid_next     = process_id;
                    granted_next = 1'b0;
                    status_next  = mlqss_pkg::STAT_OK;
                    lvl_ok_next  = 32'(priority_req) < NL;
                    if (action == mlqss_pkg::ACT_DEQ)
                    begin
                        cur_next   = '0;
                        state_next = mlqss_pkg::ST_SCAN;
                    end
                    else
                    begin
                        cur_next   = mlqss_pkg::level_t'(priority_req);
                        state_next = mlqss_pkg::ST_EXEC;
                    end
                end
                else
                begin
                    state_next = mlqss_pkg::ST_IDLE;
                end
            end

            mlqss_pkg::ST_EXEC:
            begin
                case (act_reg)
                    mlqss_pkg::ACT_ENQ:
                    begin
                        if (lvl_ok_reg && count_reg[cur_reg] <
                            mlqss_pkg::count_t'(mlqss_pkg::QUEUE_DEPTH))
                        begin
                            mem_req.we    = 1'b1;
                            mem_req.addr  = mlqss_pkg::slot_addr(cur_reg, wr_pos);
                            mem_req.wdata = pid_reg;
                            count_next[cur_reg]    = count_reg[cur_reg] + 1'b1;
                            nonempty_next[cur_reg] = 1'b1;
                        end
                        else
                        begin
                            status_next = mlqss_pkg::STAT_DROP;
                        end
                    end
                    mlqss_pkg::ACT_SLOT:
                    begin
                        if (lvl_ok_reg && credit_reg[cur_reg] != '0)
                        begin
                            credit_next[cur_reg] = credit_reg[cur_reg] - 1'b1;
                        end
                    end
                    default:
                    begin
                        status_next = mlqss_pkg::STAT_OK;
                    end
                endcase
                state_next = mlqss_pkg::ST_RESP;
            end

            mlqss_pkg::ST_SCAN:
            begin
                if (count_reg[cur_reg] != '0 && credit_reg[cur_reg] != '0)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.addr  = mlqss_pkg::slot_addr(cur_reg, head_reg[cur_reg]);
                    head_next[cur_reg]     = head_inc;
                    count_next[cur_reg]    = count_reg[cur_reg] - 1'b1;
                    nonempty_next[cur_reg] = count_reg[cur_reg] != mlqss_pkg::count_t'(1);
                    granted_next = 1'b1;
                    state_next   = mlqss_pkg::ST_RESP;
                end
                else if (cur_reg == mlqss_pkg::level_t'(NL - 1))
                begin
                    for (int lv = 0; lv < NL; lv++)
                    begin
                        credit_next[lv] = mlqss_pkg::credit_init(lv);
                    end
                    status_next = mlqss_pkg::STAT_RELOAD;
                    state_next  = mlqss_pkg::ST_RESP;
                end
                else
                begin
                    cur_next = cur_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = mlqss_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy       = !(state_reg == mlqss_pkg::ST_IDLE ||
                          state_reg == mlqss_pkg::ST_RESP);
    assign done       = state_reg == mlqss_pkg::ST_RESP;
    assign granted    = granted_reg;
    assign granted_id = granted_reg ? rd_data : '0;
    assign status     = status_reg;
    assign all_empty  = ~|nonempty_reg;

    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && granted_reg) |-> status_reg == mlqss_pkg::STAT_OK)
        else $error("grant reported with non-ok status");

    a_nonempty_track: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mlqss_pkg::ST_SCAN |->
            nonempty_reg[cur_reg] == (count_reg[cur_reg] != '0))
        else $error("non-empty flag out of step with entry count");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transfer did not make the block busy");

    a_resp_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !start) |=> state_reg == mlqss_pkg::ST_IDLE)
        else $error("result strobe held beyond one cycle");

    a_reload_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status_reg == mlqss_pkg::STAT_RELOAD) |->
            credit_reg[0] == mlqss_pkg::credit_init(0))
        else $error("credits not reloaded after failed dequeue");

endmodule

// ===== src/multilevel_queue_slot_scheduler_top.sv =====
// Multi-level ready queue scheduler: one FIFO of process ids per priority
// level (level 0 highest) plus a slot credit per level. Raise start with an
// action while busy is low and the transfer is taken at that clock edge.
// Exactly one result follows, shown for a single cycle with done high; the
// receiver cannot stall it, so capture it on that cycle. Enqueue and use-slot
// run through the execute state and then the result state. A dequeue walks
// the levels one per cycle through a single compare unit and then reads the
// queue memory once; when nothing is eligible, credits are reloaded and
// status reports it. A new transfer may be taken in the same cycle that done
// is high. all_empty reflects the queues after the step just reported.
module multilevel_queue_slot_scheduler_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] action,
    input  logic [2:0] priority_req,
    input  logic [7:0] process_id,
    output logic       done,
    output logic [7:0] granted_id,
    output logic       granted,
    output logic [1:0] status,
    output logic       all_empty
);

    mlqss_pkg::mem_req_t mem_req;
    mlqss_pkg::id_t      rd_data;

    // sequencer: level table, scan and result registers
    mlqss_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .action       (action),
        .priority_req (priority_req),
        .process_id   (process_id),
        .rd_data      (rd_data),
        .mem_req      (mem_req),
        .busy         (busy),
        .done         (done),
        .granted_id   (granted_id),
        .granted      (granted),
        .status       (status),
        .all_empty    (all_empty)
    );

    // queue store: every level's FIFO slots in one memory with registered read
    mlqss_store u_store (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

endmodule

// ===== tb/mlqss_outcome_checker.sv =====
module mlqss_outcome_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       busy,
    input  logic [1:0] action,
    input  logic [2:0] priority_req,
    input  logic [7:0] process_id,
    input  logic       done,
    input  logic [7:0] granted_id,
    input  logic       granted,
    input  logic [1:0] status,
    input  logic       all_empty,
    output int         mismatches,
    output int         outstanding,
    output int         results_seen,
    output int         grants_seen,
    output int         drops_seen,
    output int         reloads_seen
);

    typedef struct {
        mlqss_pkg::id_t     gid;
        logic               granted;
        mlqss_pkg::status_t st;
        logic               empty;
    } outcome_t;

    // scheduler image: ids per level, head, fill and slot credit
    mlqss_pkg::id_t     lane_ids [mlqss_pkg::PRIO_LEVELS][mlqss_pkg::QUEUE_DEPTH];
    mlqss_pkg::ptr_t    lane_head [mlqss_pkg::PRIO_LEVELS];
    mlqss_pkg::count_t  lane_fill [mlqss_pkg::PRIO_LEVELS];
    mlqss_pkg::credit_t lane_credit [mlqss_pkg::PRIO_LEVELS];

    outcome_t due_outcomes[$];

    function automatic void reload_credits();
        for (int lv = 0; lv < mlqss_pkg::PRIO_LEVELS; lv++)
        begin
            lane_credit[lv] = mlqss_pkg::credit_t'(mlqss_pkg::PRIO_LEVELS - lv);
        end
    endfunction

    function automatic void clear_lanes();
        for (int lv = 0; lv < mlqss_pkg::PRIO_LEVELS; lv++)
        begin
            lane_head[lv] = '0;
            lane_fill[lv] = '0;
        end
        reload_credits();
    endfunction

    function automatic outcome_t schedule_step(logic [1:0] act, logic [2:0] lvl,
                                               mlqss_pkg::id_t pid);
        outcome_t o;
        int       pos;
        bit       found;
        o.gid     = '0;
        o.granted = 1'b0;
        o.st      = mlqss_pkg::STAT_OK;
        found     = 1'b0;
        case (act)
            mlqss_pkg::ACT_ENQ:
            begin
                if (int'(lvl) < mlqss_pkg::PRIO_LEVELS &&
                    int'(lane_fill[lvl]) < mlqss_pkg::QUEUE_DEPTH)
                begin
                    pos = (int'(lane_head[lvl]) + int'(lane_fill[lvl]))
                          % mlqss_pkg::QUEUE_DEPTH;
                    lane_ids[lvl][pos] = pid;
                    lane_fill[lvl] = lane_fill[lvl] + 1'b1;
                end
                else
                begin
                    o.st = mlqss_pkg::STAT_DROP;
                end
            end
            mlqss_pkg::ACT_DEQ:
            begin
                // lowest-numbered level with work and credit wins
                for (int lv = 0; lv < mlqss_pkg::PRIO_LEVELS; lv++)
                begin
                    if (!found && lane_fill[lv] != 0 && lane_credit[lv] != 0)
                    begin
                        o.gid         = lane_ids[lv][lane_head[lv]];
                        lane_head[lv] = mlqss_pkg::ptr_t'((int'(lane_head[lv]) + 1)
                                                          % mlqss_pkg::QUEUE_DEPTH);
                        lane_fill[lv] = lane_fill[lv] - 1'b1;
                        o.granted     = 1'b1;
                        found         = 1'b1;
                    end
                end
                if (!found)
                begin
                    reload_credits();
                    o.st = mlqss_pkg::STAT_RELOAD;
                end
            end
            mlqss_pkg::ACT_SLOT:
            begin
                if (int'(lvl) < mlqss_pkg::PRIO_LEVELS && lane_credit[lvl] != 0)
                    lane_credit[lvl] = lane_credit[lvl] - 1'b1;
            end
            default: ;
        endcase
        o.empty = 1'b1;
        for (int lv = 0; lv < mlqss_pkg::PRIO_LEVELS; lv++)
        begin
            if (lane_fill[lv] != 0)
                o.empty = 1'b0;
        end
        return o;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        $display("%0t: %s: got %0d, want %0d", $realtime, what, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        outcome_t want;
        if (!rst_n)
        begin
            clear_lanes();
            due_outcomes.delete();
            mismatches   = 0;
            results_seen = 0;
            grants_seen  = 0;
            drops_seen   = 0;
            reloads_seen = 0;
            outstanding <= 0;
        end
        else
        begin
            // queue the new transfer first so a same-edge result pops the older one
            if (start && !busy)
                due_outcomes.push_back(schedule_step(action, priority_req, process_id));
            if (done)
            begin
                results_seen++;
                if (due_outcomes.size() == 0)
                begin
                    report_mismatch("result with no transfer outstanding", 1, 0);
                end
                else
                begin
                    want = due_outcomes.pop_front();
                    if (granted_id !== want.gid)
                        report_mismatch("granted_id", granted_id, want.gid);
                    if (granted !== want.granted)
                        report_mismatch("granted", granted, want.granted);
                    if (status !== want.st)
                        report_mismatch("status", status, want.st);
                    if (all_empty !== want.empty)
                        report_mismatch("all_empty", all_empty, want.empty);
                    if (want.granted)
                        grants_seen++;
                    if (want.st == mlqss_pkg::STAT_DROP)
                        drops_seen++;
                    if (want.st == mlqss_pkg::STAT_RELOAD)
                        reloads_seen++;
                end
            end
            outstanding <= due_outcomes.size();
        end
    end

endmodule

// ===== tb/multilevel_queue_slot_scheduler_top_tb.sv =====
module multilevel_queue_slot_scheduler_top_tb;

    // the block leaves this action code unassigned; it must change nothing
    localparam logic [1:0] ACT_SPARE = 2'd3;

    // shapes of the random stretches
    localparam int MODE_MIX    = 0;
    localparam int MODE_FILL   = 1;
    localparam int MODE_DRAIN  = 2;
    localparam int MODE_STARVE = 3;

    localparam int EPISODES    = 31;
    localparam int EPISODE_LEN = 50;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [1:0] action;
    logic [2:0] priority_req;
    logic [7:0] process_id;
    logic       done;
    logic [7:0] granted_id;
    logic       granted;
    logic [1:0] status;
    logic       all_empty;

    int mismatches;
    int outstanding;
    int results_seen;
    int grants_seen;
    int drops_seen;
    int reloads_seen;

    multilevel_queue_slot_scheduler_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .priority_req (priority_req),
        .process_id   (process_id),
        .done         (done),
        .granted_id   (granted_id),
        .granted      (granted),
        .status       (status),
        .all_empty    (all_empty)
    );

    // the checker watches both sides, predicts every result and counts faults
    mlqss_outcome_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .priority_req (priority_req),
        .process_id   (process_id),
        .done         (done),
        .granted_id   (granted_id),
        .granted      (granted),
        .status       (status),
        .all_empty    (all_empty),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .results_seen (results_seen),
        .grants_seen  (grants_seen),
        .drops_seen   (drops_seen),
        .reloads_seen (reloads_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one request and hold it until the block takes the transfer.
    // Draw a random idle gap first unless the stretch is calm.
    // Leave start high across back-to-back transfers rather than dropping
    // and raising it in the same step.
    task automatic send_item(logic [1:0] act, logic [2:0] lvl, logic [7:0] pid, bit calm);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        action       <= act;
        priority_req <= lvl;
        process_id   <= pid;
        start        <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Hold the sender off until every predicted result has come back.
    // The first edge lets the checker count the transfer just taken.
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // One random stretch. Fill piles requests onto one hot level until it
    // overflows, drain empties the queues so dequeues hit the reload path,
    // starve burns slot credit so busy levels become ineligible.
    task automatic run_episode(int mode, bit calm);
        int         roll;
        logic [2:0] hot;
        logic [2:0] lvl;
        logic [1:0] act;
        hot = 3'($urandom_range(0, 7));
        repeat (EPISODE_LEN)
        begin
            roll = $urandom_range(0, 99);
            lvl  = 3'($urandom_range(0, 7));
            act  = ACT_SPARE;
            case (mode)
                MODE_FILL:
                begin
                    if (roll < 75)      act = mlqss_pkg::ACT_ENQ;
                    else if (roll < 90) act = mlqss_pkg::ACT_DEQ;
                    else if (roll < 97) act = mlqss_pkg::ACT_SLOT;
                    if ($urandom_range(0, 9) < 8)
                        lvl = hot;
                end
                MODE_DRAIN:
                begin
                    if (roll < 25)      act = mlqss_pkg::ACT_ENQ;
                    else if (roll < 85) act = mlqss_pkg::ACT_DEQ;
                    else if (roll < 97) act = mlqss_pkg::ACT_SLOT;
                end
                MODE_STARVE:
                begin
                    if (roll < 25)      act = mlqss_pkg::ACT_ENQ;
                    else if (roll < 55) act = mlqss_pkg::ACT_DEQ;
                    else if (roll < 97) act = mlqss_pkg::ACT_SLOT;
                    if ($urandom_range(0, 1) == 0)
                        lvl = hot;
                end
                MODE_MIX:
                begin
                    if (roll < 45)      act = mlqss_pkg::ACT_ENQ;
                    else if (roll < 80) act = mlqss_pkg::ACT_DEQ;
                    else if (roll < 96) act = mlqss_pkg::ACT_SLOT;
                end
                default: ;
            endcase
            send_item(act, lvl, 8'($urandom_range(0, 255)), calm);
        end
    endtask

    initial
    begin
        start        <= 1'b0;
        action       <= mlqss_pkg::ACT_ENQ;
        priority_req <= '0;
        process_id   <= '0;
        rst_n        <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening, from reset: credits run 8 down to 1.
        // Dequeue with every queue empty: nothing granted, credits reload.
        send_item(mlqss_pkg::ACT_DEQ, 3'd0, 8'h00, 1'b0);
        // Spare action code: no change, status ok.
        send_item(ACT_SPARE, 3'd5, 8'hAA, 1'b0);
        // Spend the last credit of level 7, then try again: hold at zero.
        send_item(mlqss_pkg::ACT_SLOT, 3'd7, 8'h00, 1'b0);
        send_item(mlqss_pkg::ACT_SLOT, 3'd7, 8'hFF, 1'b0);
        // Work waiting on a level with no credit: dequeue reloads instead.
        send_item(mlqss_pkg::ACT_ENQ, 3'd7, 8'hFF, 1'b0);
        send_item(mlqss_pkg::ACT_DEQ, 3'd0, 8'h00, 1'b0);
        // Credit back after the reload, and a dequeue must not spend it.
        send_item(mlqss_pkg::ACT_DEQ, 3'd0, 8'h00, 1'b1);
        // Ids 00 and 55 on the top level and AA on level 3, then drain in priority order.
        send_item(mlqss_pkg::ACT_ENQ, 3'd0, 8'h00, 1'b1);
        send_item(mlqss_pkg::ACT_ENQ, 3'd0, 8'h55, 1'b1);
        send_item(mlqss_pkg::ACT_ENQ, 3'd3, 8'hAA, 1'b0);
        send_item(mlqss_pkg::ACT_DEQ, 3'd7, 8'hFF, 1'b0);
        send_item(mlqss_pkg::ACT_SLOT, 3'd0, 8'hFF, 1'b0);
        send_item(mlqss_pkg::ACT_DEQ, 3'd0, 8'h00, 1'b0);
        send_item(mlqss_pkg::ACT_DEQ, 3'd0, 8'h00, 1'b0);
        // Walking-one ids across every level, then take two back.
        for (int lv = 0; lv < mlqss_pkg::PRIO_LEVELS; lv++)
        begin
            send_item(mlqss_pkg::ACT_ENQ, 3'(lv), 8'(1 << lv), lv[0]);
        end
        send_item(mlqss_pkg::ACT_DEQ, 3'd0, 8'h00, 1'b0);
        send_item(mlqss_pkg::ACT_DEQ, 3'd0, 8'h00, 1'b1);
        wait_drained();

        // Random stretches; each of the four shapes in turn, some without idling,
        // and now and then hold the sender until the pipe is empty.
        for (int ep = 0; ep < EPISODES; ep++)
        begin
            run_episode(ep % 4, (ep % 5) == 2);
            if ((ep % 6) == 5)
                wait_drained();
        end

        // Drain, then allow for a slow dequeue still on its way out.
        wait_drained();
        repeat (mlqss_pkg::PRIO_LEVELS + 4) @(posedge clk);

        $display("covered %0d results: %0d grants, %0d drops at a full level,",
                 results_seen, grants_seen, drops_seen);
        $display("and %0d credit reloads", reloads_seen);
        if (mismatches == 0)
        begin
            $display("multilevel_queue_slot_scheduler_top: match");
        end
        else
        begin
            $display("%0d faults found", mismatches);
            $display("multilevel_queue_slot_scheduler_top: mismatch");
        end
        $finish;
    end

    // Guard against a hung handshake: a correct run needs well under a tenth of this.
    initial
    begin
        #3000000;
        $display("timed out with %0d results outstanding", outstanding);
        $display("multilevel_queue_slot_scheduler_top: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
src/mlqss_pkg.sv
src/mlqss_store.sv
src/mlqss_seq.sv
src/multilevel_queue_slot_scheduler_top.sv
tb/mlqss_outcome_checker.sv
tb/multilevel_queue_slot_scheduler_top_tb.sv
